FILE: design/pclt_pkg.sv
// ----------------------------------------------------------------------------
// pclt_pkg: shared types and constants
// Widths, register codes and pipeline payload types of the colormap,
// label and threshold pixel unit.
// ----------------------------------------------------------------------------
package pclt_pkg;

    localparam int TABLE_DEPTH     = 256;
    localparam int SAMPLE_BITS     = 32;
    localparam int SCALE_FRAC_BITS = 24;

    localparam int WORD_W    = 32;
    localparam int ENTRY_W   = 8;
    localparam int CNT_REG_W = 9;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam int TBL_AW  = $clog2(TABLE_DEPTH);
    localparam int DIFF_W  = (SAMPLE_BITS > WORD_W) ? SAMPLE_BITS : WORD_W;
    localparam int EXT_W   = DIFF_W + 1;
    localparam int PROD_W  = DIFF_W + WORD_W;
    localparam int T_W     = SCALE_FRAC_BITS + 1;
    localparam int P2_W    = T_W + TBL_AW;
    localparam int IDXC_W  = ((ENTRY_W > TBL_AW) ? ENTRY_W : TBL_AW) + 1;
    localparam int CMP_W   = ((TBL_AW + 1) > CNT_REG_W) ? (TBL_AW + 1) : CNT_REG_W;

    localparam logic [T_W-1:0]    T_ONE     = T_W'(1) << SCALE_FRAC_BITS;
    localparam logic [P2_W:0]     ROUND_HALF = (P2_W + 1)'(1) << (SCALE_FRAC_BITS - 1);
    localparam logic [WORD_W-1:0] SCALE_RST = WORD_W'(1) << SCALE_FRAC_BITS;
    localparam logic [CNT_REG_W-1:0] COUNT_RST = CNT_REG_W'(TABLE_DEPTH);
    localparam logic [7:0]        PIX_SET   = 8'hff;
    localparam logic [7:0]        PIX_CLEAR = 8'h00;

    localparam logic [MODE_W-1:0] MODE_COLOR      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LABEL      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_THRESH     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_THRESH_ALT = 2'd3;

    localparam logic ACT_MAP   = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_LABEL_MASK  = 3'd1,
        CFG_LOWER_LIMIT = 3'd2,
        CFG_UPPER_LIMIT = 3'd3,
        CFG_WINDOW_LOW  = 3'd4,
        CFG_SCALE_Q     = 3'd5,
        CFG_COLOR_COUNT = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [WORD_W-1:0]        label_mask;
        logic signed [WORD_W-1:0] lower_limit;
        logic signed [WORD_W-1:0] upper_limit;
        logic signed [WORD_W-1:0] window_low;
        logic [WORD_W-1:0]        scale_q;
        logic [TBL_AW-1:0]        cnt_m1;
    } t_cfg;

    typedef struct packed {
        logic               is_wr;
        logic               alpha;
        logic               hit;
        logic [ENTRY_W-1:0] wr_idx;
        logic [WORD_W-1:0]  wr_rgba;
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              pos;
        logic [PROD_W-1:0] prod;
    } t_front;

    typedef struct packed {
        t_op               op;
        logic [TBL_AW-1:0] idx;
    } t_index;

endpackage

FILE: design/pixel_colormap_label_threshold_unit.sv
// ----------------------------------------------------------------------------
// pixel_colormap_label_threshold_unit: window/level colormap pixel mapper
// A sample's result is presented from the output register of stage five.
// Throughput: one transfer per cycle while not stalled; five register stages, stall-driven per stage.
// Reset clears all pipeline valid bits and loads the configuration defaults.
// The color table is not cleared; entries hold nothing useful until written.
// ----------------------------------------------------------------------------
module pixel_colormap_label_threshold_unit
    import pclt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [WORD_W-1:0]      i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_action,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [ENTRY_W-1:0]     i_entry_index,
    input  logic [WORD_W-1:0]      i_entry_rgba,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [WORD_W-1:0]      o_pixel_value,
    output logic                   o_alpha_only
);

    t_cfg   cfg;
    logic   front_ready;
    logic   front_valid;
    t_front front_data;
    logic   index_ready;
    logic   index_valid;
    t_index index_data;
    logic   table_ready;

    pclt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pclt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .o_ready       (front_ready),
        .i_action      (i_action),
        .i_sample      (i_sample),
        .i_entry_index (i_entry_index),
        .i_entry_rgba  (i_entry_rgba),
        .o_valid       (front_valid),
        .i_dn_ready    (index_ready),
        .o_data        (front_data)
    );

    pclt_index u_index (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (front_valid),
        .o_ready    (index_ready),
        .i_data     (front_data),
        .o_valid    (index_valid),
        .i_dn_ready (table_ready),
        .o_data     (index_data)
    );

    pclt_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (index_valid),
        .o_ready       (table_ready),
        .i_data        (index_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_value (o_pixel_value),
        .o_alpha_only  (o_alpha_only)
    );

    assign o_stall = !front_ready;

endmodule

FILE: design/pclt_cfg_regs.sv
// ----------------------------------------------------------------------------
// pclt_cfg_regs: configuration registers
// Holds the mode, limits, window and scale settings and derives the
// clamped top table index from the color count.
// ----------------------------------------------------------------------------
module pclt_cfg_regs
    import pclt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [MODE_W-1:0]    r_mode;
    logic [WORD_W-1:0]    r_label_mask;
    logic [WORD_W-1:0]    r_lower;
    logic [WORD_W-1:0]    r_upper;
    logic [WORD_W-1:0]    r_window_low;
    logic [WORD_W-1:0]    r_scale;
    logic [CNT_REG_W-1:0] r_count;
    logic [CMP_W-1:0]     count_ext;
    logic [CMP_W-1:0]     cnt_m1_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_COLOR;
            r_label_mask <= '0;
            r_lower      <= '0;
            r_upper      <= '0;
            r_window_low <= '0;
            r_scale      <= SCALE_RST;
            r_count      <= COUNT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:        r_mode       <= i_cfg_data[MODE_W-1:0];
                CFG_LABEL_MASK:  r_label_mask <= i_cfg_data;
                CFG_LOWER_LIMIT: r_lower      <= i_cfg_data;
                CFG_UPPER_LIMIT: r_upper      <= i_cfg_data;
                CFG_WINDOW_LOW:  r_window_low <= i_cfg_data;
                CFG_SCALE_Q:     r_scale      <= i_cfg_data;
                CFG_COLOR_COUNT: r_count      <= i_cfg_data[CNT_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        count_ext = CMP_W'(r_count);
        if (count_ext == '0) begin
            cnt_m1_ext = '0;
        end else if (count_ext > CMP_W'(TABLE_DEPTH)) begin
            cnt_m1_ext = CMP_W'(TABLE_DEPTH - 1);
        end else begin
            cnt_m1_ext = count_ext - CMP_W'(1);
        end
    end

    assign o_cfg.mode        = r_mode;
    assign o_cfg.label_mask  = r_label_mask;
    assign o_cfg.lower_limit = r_lower;
    assign o_cfg.upper_limit = r_upper;
    assign o_cfg.window_low  = r_window_low;
    assign o_cfg.scale_q     = r_scale;
    assign o_cfg.cnt_m1      = cnt_m1_ext[TBL_AW-1:0];

endmodule

FILE: design/pclt_front.sv
// ----------------------------------------------------------------------------
// pclt_front: decode, window offset and scale multiply
// Stage one resolves the mask modes and offsets the sample by the window
// low value; stage two multiplies the offset by the scale factor.
// ----------------------------------------------------------------------------
module pclt_front
    import pclt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_action,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [ENTRY_W-1:0]     i_entry_index,
    input  logic [WORD_W-1:0]      i_entry_rgba,
    output logic                   o_valid,
    input  logic                   i_dn_ready,
    output t_front                 o_data
);

    logic              r_v1;
    t_op               r_op1;
    logic              r_pos1;
    logic [DIFF_W-1:0] r_d1;
    logic              r_v2;
    t_front            r_s2;

    logic              ce1;
    logic              ce2;
    logic [EXT_W-1:0]  ext_s;
    logic [EXT_W-1:0]  ext_w;
    logic [EXT_W-1:0]  ext_lo;
    logic [EXT_W-1:0]  ext_hi;
    logic [EXT_W-1:0]  diff;
    t_op               n_op1;

    assign ce2     = !r_v2 || i_dn_ready;
    assign ce1     = !r_v1 || ce2;
    assign o_ready = ce1;

    always_comb begin
        ext_s  = {{(EXT_W-SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}}, i_sample};
        ext_w  = {{(EXT_W-WORD_W){i_cfg.window_low[WORD_W-1]}}, i_cfg.window_low};
        ext_lo = {{(EXT_W-WORD_W){i_cfg.lower_limit[WORD_W-1]}}, i_cfg.lower_limit};
        ext_hi = {{(EXT_W-WORD_W){i_cfg.upper_limit[WORD_W-1]}}, i_cfg.upper_limit};
        diff   = ext_s - ext_w;

        n_op1.is_wr   = (i_action == ACT_WRITE);
        n_op1.wr_idx  = i_entry_index;
        n_op1.wr_rgba = i_entry_rgba;
        case (i_cfg.mode) inside
            MODE_LABEL: begin
                n_op1.alpha = 1'b1;
                n_op1.hit   = |(ext_s[WORD_W-1:0] & i_cfg.label_mask);
            end
            MODE_THRESH, MODE_THRESH_ALT: begin
                n_op1.alpha = 1'b1;
                n_op1.hit   = ($signed(ext_s) >= $signed(ext_lo))
                           && ($signed(ext_s) <= $signed(ext_hi));
            end
            default: begin
                n_op1.alpha = 1'b0;
                n_op1.hit   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ce1) begin
                r_v1 <= i_valid;
            end
            if (ce2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce1) begin
            r_op1  <= n_op1;
            r_pos1 <= $signed(ext_s) > $signed(ext_w);
            r_d1   <= diff[DIFF_W-1:0];
        end
        if (ce2) begin
            r_s2.op   <= r_op1;
            r_s2.pos  <= r_pos1;
            r_s2.prod <= {{WORD_W{1'b0}}, r_d1} * {{DIFF_W{1'b0}}, i_cfg.scale_q};
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_s2;

`ifndef SYNTHESIS
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !i_dn_ready) |=> (r_v2 && $stable(r_s2)))
        else $error("front stage changed while stalled");
`endif

endmodule

FILE: design/pclt_index.sv
// ----------------------------------------------------------------------------
// pclt_index: clamp, count scaling and rounding
// Stage three clamps the scaled offset to the unit range and multiplies it
// by the top table index; stage four rounds half up to the table index.
// ----------------------------------------------------------------------------
module pclt_index
    import pclt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_front i_data,
    output logic   o_valid,
    input  logic   i_dn_ready,
    output t_index o_data
);

    logic            r_v3;
    t_op             r_op3;
    logic [P2_W-1:0] r_p3;
    logic            r_v4;
    t_index          r_s4;

    logic            ce3;
    logic            ce4;
    logic [T_W-1:0]  t_frac;
    logic [P2_W:0]   rounded;

    assign ce4     = !r_v4 || i_dn_ready;
    assign ce3     = !r_v3 || ce4;
    assign o_ready = ce3;

    always_comb begin
        if (!i_data.pos) begin
            t_frac = '0;
        end else if (i_data.prod >= PROD_W'(T_ONE)) begin
            t_frac = T_ONE;
        end else begin
            t_frac = i_data.prod[T_W-1:0];
        end
        rounded = {1'b0, r_p3} + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ce3) begin
                r_v3 <= i_valid;
            end
            if (ce4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce3) begin
            r_op3 <= i_data.op;
            r_p3  <= {{TBL_AW{1'b0}}, t_frac} * {{T_W{1'b0}}, i_cfg.cnt_m1};
        end
        if (ce4) begin
            r_s4.op  <= r_op3;
            r_s4.idx <= rounded[SCALE_FRAC_BITS +: TBL_AW];
        end
    end

    assign o_valid = r_v4;
    assign o_data  = r_s4;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !r_s4.op.is_wr && !r_s4.op.alpha) |-> (r_s4.idx <= i_cfg.cnt_m1))
        else $error("table index beyond color count");
`endif

endmodule

FILE: design/pclt_table.sv
// ----------------------------------------------------------------------------
// pclt_table: color table and output register
// Table writes and lookups reach the memory in transfer order through one
// port; lookups and mask results land in the output register.
// ----------------------------------------------------------------------------
module pclt_table
    import pclt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_index            i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [WORD_W-1:0] o_pixel_value,
    output logic              o_alpha_only
);

    logic [WORD_W-1:0] r_mem [TABLE_DEPTH];
    logic              r_v5;
    logic              r_alpha5;
    logic              r_hit5;
    logic [WORD_W-1:0] r_rd5;

    logic              ce5;
    logic [IDXC_W-1:0] wr_idx_ext;
    logic              wr_ok;

    assign ce5        = !r_v5 || !i_stall;
    assign o_ready    = ce5;
    assign wr_idx_ext = IDXC_W'(i_data.op.wr_idx);
    assign wr_ok      = wr_idx_ext < IDXC_W'(TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (ce5) begin
            r_v5 <= i_valid && !i_data.op.is_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce5 && i_valid) begin
            if (i_data.op.is_wr) begin
                if (wr_ok) begin
                    r_mem[wr_idx_ext[TBL_AW-1:0]] <= i_data.op.wr_rgba;
                end
            end else begin
                r_rd5 <= r_mem[i_data.idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce5) begin
            r_alpha5 <= i_data.op.alpha;
            r_hit5   <= i_data.op.hit;
        end
    end

    assign o_valid       = r_v5;
    assign o_alpha_only  = r_alpha5;
    assign o_pixel_value = r_alpha5
                         ? {{(WORD_W-8){1'b0}}, (r_hit5 ? PIX_SET : PIX_CLEAR)}
                         : r_rd5;

`ifndef SYNTHESIS
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ce5 && i_valid && i_data.op.is_wr) |=> !r_v5)
        else $error("table write produced a result");
`endif

endmodule
